// ===== rtl/rgb_led_chain_serializer_defines.svh =====
// assertion macros for the led chain serializer
// expects clk and arst_n in the scope of each use
`ifndef RGB_LED_CHAIN_SERIALIZER_DEFINES_SVH
`define RGB_LED_CHAIN_SERIALIZER_DEFINES_SVH

// same-cycle implication
`define RLCS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLCS_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rlcs_pkg.sv =====
// shared types and constants for the led chain serializer
// no dependencies
`default_nettype none

package rlcs_pkg;

	localparam int OP_W        = 2;
	localparam int LED_IDX_W   = 4;
	localparam int COLOR_W     = 8;
	localparam int WORD_W      = 24;
	localparam int TIMER_W     = 16;
	localparam int BIT_CNT_W   = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int BITS_PER_LED = 24;
	localparam int LED_ADDR_SPAN = 2 ** LED_IDX_W;

	// queue depth must be a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(BITS_PER_LED - 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_LATCH     = CFG_IDX_W'(4);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_START,
		CMD_TICK,
		CMD_NOP
	} cmd_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW,
		PH_LATCH
	} phase_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [LED_IDX_W-1:0]   idx;
		logic [WORD_W-1:0]      word;
	} cmd_t;

	typedef struct packed {
		logic [7:0]         zero_high;
		logic [7:0]         zero_low;
		logic [7:0]         one_high;
		logic [7:0]         one_low;
		logic [TIMER_W-1:0] latch;
	} cfg_regs_t;

endpackage

`default_nettype wire

// ===== rtl/rlcs_in_if.sv =====
// input word channel: command op and colour payload
// depends on rlcs_pkg
`default_nettype none

interface rlcs_in_if import rlcs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [LED_IDX_W-1:0] led_index;
	logic [COLOR_W-1:0]   red;
	logic [COLOR_W-1:0]   green;
	logic [COLOR_W-1:0]   blue;

	modport source (output valid, op, led_index, red, green, blue, input ready);
	modport sink (input valid, op, led_index, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/rlcs_out_if.sv =====
// result word channel: line level and frame status
// no dependencies
`default_nettype none

interface rlcs_out_if ();
	logic valid;
	logic ready;
	logic pin_level;
	logic busy_res;
	logic frame_done;

	modport source (output valid, pin_level, busy_res, frame_done, input ready);
	modport sink (input valid, pin_level, busy_res, frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/rlcs_cfg_if.sv =====
// configuration write channel: register index and data
// depends on rlcs_pkg
`default_nettype none

interface rlcs_cfg_if import rlcs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rlcs_front.sv =====
// front stage: accepts input words and classifies them into commands
// depends on rlcs_pkg and rlcs_in_if
`default_nettype none

module rlcs_front import rlcs_pkg::*; #(
	parameter int NUM_LEDS = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rlcs_in_if.sink    cmd,
	input  wire logic  q_full,
	output logic       valid_s1,
	output cmd_t       cmd_s1
);

	cmd_t cmd_d;
	logic take;

	assign cmd.ready = !valid_s1 || !q_full;
	assign take      = cmd.valid && cmd.ready;

	always_comb begin
		cmd_d.idx  = cmd.led_index;
		cmd_d.word = {cmd.green, cmd.red, cmd.blue};
		case (op_t'(cmd.op))
			OP_WRITE: begin
				cmd_d.kind = (32'(cmd.led_index) < NUM_LEDS) ? CMD_WRITE : CMD_NOP;
			end
			OP_START: cmd_d.kind = CMD_START;
			OP_TICK:  cmd_d.kind = CMD_TICK;
			default:  cmd_d.kind = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rlcs_queue.sv =====
// short command queue between front and back
// depends on rlcs_pkg
`default_nettype none

module rlcs_queue import rlcs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output cmd_t      head
);

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rlcs_back.sv =====
// back stage: pixel store, waveform sequencer and result register
// depends on rlcs_pkg, rlcs_out_if and the assertion macro header
`default_nettype none
`include "rgb_led_chain_serializer_defines.svh"

module rlcs_back import rlcs_pkg::*; #(
	parameter int NUM_LEDS = 12
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  wire cmd_t      head,
	output logic           pop,
	input  wire cfg_regs_t cfg,
	rlcs_out_if.source     res
);

	localparam int LED_W       = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int STORE_DEPTH = (NUM_LEDS < LED_ADDR_SPAN) ? NUM_LEDS : LED_ADDR_SPAN;
	localparam int STORE_IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);

	logic [WORD_W-1:0]    store_q [STORE_DEPTH];
	phase_t               phase_q, phase_d;
	logic [TIMER_W-1:0]   timer_q, timer_d;
	logic [BIT_CNT_W-1:0] bit_q, bit_d;
	logic [LED_W-1:0]     led_q, led_d;
	logic [WORD_W-1:0]    shift_q, shift_d;
	logic                 line_q, line_d;
	logic                 done_d;
	logic                 res_valid_q;
	logic                 res_pin_q;
	logic                 res_busy_q;
	logic                 res_done_q;

	logic                 exec;
	logic                 is_tick;
	logic                 load_word;
	logic [WORD_W-1:0]    store_rd;
	logic [WORD_W-1:0]    cur_word;
	logic [TIMER_W-1:0]   lim_raw;
	logic [TIMER_W-1:0]   lim;
	logic [TIMER_W-1:0]   timer_inc;
	logic                 tim_end;

	assign exec    = head_valid && (!res_valid_q || res.ready);
	assign pop     = exec;
	assign is_tick = exec && (head.kind == CMD_TICK);

	// each led word is fetched as its first bit begins
	assign store_rd  = (32'(led_q) < STORE_DEPTH) ? store_q[led_q[STORE_IDX_W-1:0]] : '0;
	assign load_word = (phase_q == PH_HIGH) && (timer_q == '0) && (bit_q == '0);
	assign cur_word  = load_word ? store_rd : shift_q;

	always_comb begin
		case (phase_q)
			PH_HIGH:  lim_raw = {8'h00, cur_word[WORD_W-1] ? cfg.one_high : cfg.zero_high};
			PH_LOW:   lim_raw = {8'h00, shift_q[WORD_W-1] ? cfg.one_low : cfg.zero_low};
			PH_LATCH: lim_raw = cfg.latch;
			default:  lim_raw = TIMER_W'(1);
		endcase
	end

	// a zero length acts as one tick
	assign lim       = (lim_raw == '0) ? TIMER_W'(1) : lim_raw;
	assign timer_inc = timer_q + 1'b1;
	assign tim_end   = (timer_inc >= lim);

	// next state
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		bit_d   = bit_q;
		led_d   = led_q;
		shift_d = shift_q;
		if (exec) begin
			case (head.kind)
				CMD_START: begin
					if (phase_q == PH_IDLE) begin
						led_d   = '0;
						bit_d   = '0;
						timer_d = '0;
						phase_d = PH_HIGH;
					end
				end
				CMD_TICK: begin
					case (phase_q)
						PH_HIGH: begin
							shift_d = cur_word;
							timer_d = timer_inc;
							if (tim_end) begin
								timer_d = '0;
								phase_d = PH_LOW;
							end
						end
						PH_LOW: begin
							timer_d = timer_inc;
							if (tim_end) begin
								timer_d = '0;
								shift_d = {shift_q[WORD_W-2:0], 1'b0};
								phase_d = PH_HIGH;
								if (bit_q == BIT_LAST) begin
									bit_d = '0;
									if (led_q == LED_LAST) begin
										led_d   = '0;
										phase_d = PH_LATCH;
									end else begin
										led_d = led_q + 1'b1;
									end
								end else begin
									bit_d = bit_q + 1'b1;
								end
							end
						end
						PH_LATCH: begin
							timer_d = timer_inc;
							if (tim_end) begin
								timer_d = '0;
								phase_d = PH_IDLE;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		line_d = line_q;
		done_d = 1'b0;
		if (is_tick) begin
			line_d = (phase_q == PH_HIGH);
			done_d = (phase_q == PH_LATCH) && tim_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			bit_q       <= '0;
			led_q       <= '0;
			shift_q     <= '0;
			line_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			bit_q   <= bit_d;
			led_q   <= led_d;
			shift_q <= shift_d;
			line_q  <= line_d;
			if (exec) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_pin_q  <= line_d;
			res_busy_q <= (phase_d != PH_IDLE);
			res_done_q <= done_d;
		end
	end

	// pixel store, all off after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (exec && (head.kind == CMD_WRITE)) begin
			store_q[head.idx[STORE_IDX_W-1:0]] <= head.word;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.pin_level  = res_pin_q;
	assign res.busy_res   = res_busy_q;
	assign res.frame_done = res_done_q;

	`RLCS_ASSERT_IMP(a_done_not_busy, res_valid_q && res_done_q, !res_busy_q, "frame done while busy")
	`RLCS_ASSERT_IMP(a_bit_range, phase_q == PH_HIGH || phase_q == PH_LOW, bit_q <= BIT_LAST,
		"bit counter out of range")
	`RLCS_ASSERT_IMP(a_led_range, 1'b1, 32'(led_q) < NUM_LEDS, "led counter out of range")
	`RLCS_ASSERT_NXT(a_busy_track, exec, res_busy_q == (phase_q != PH_IDLE),
		"busy result does not match phase")

endmodule

`default_nettype wire

// ===== rtl/rgb_led_chain_serializer.sv =====
// an accepted word passes the front register, the command queue and the result register
// throughput: one word per cycle while res.ready holds; a stalled result stops the back stage
// the two-entry command queue lets the front keep accepting while a result waits
// reset: asynchronous active low; timing registers return to defaults, all leds off,
// line register low, sequencer idle, no result pending
`default_nettype none

module rgb_led_chain_serializer import rlcs_pkg::*; #(
	parameter int NUM_LEDS = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rlcs_in_if.sink    cmd,
	rlcs_out_if.source res,
	rlcs_cfg_if.sink   cfg
);

	cfg_regs_t cfg_q;
	logic      valid_s1;
	cmd_t      cmd_s1;
	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      head_valid;
	cmd_t      head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high <= 8'd13;
			cfg_q.zero_low  <= 8'd32;
			cfg_q.one_high  <= 8'd32;
			cfg_q.one_low   <= 8'd12;
			cfg_q.latch     <= 16'd2400;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ZERO_HIGH: cfg_q.zero_high <= cfg.data[7:0];
				REG_ZERO_LOW:  cfg_q.zero_low  <= cfg.data[7:0];
				REG_ONE_HIGH:  cfg_q.one_high  <= cfg.data[7:0];
				REG_ONE_LOW:   cfg_q.one_low   <= cfg.data[7:0];
				REG_LATCH:     cfg_q.latch     <= cfg.data[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	assign q_push = valid_s1 && !q_full;

	rlcs_front #(
		.NUM_LEDS (NUM_LEDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.q_full   (q_full),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1)
	);

	rlcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (cmd_s1),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	rlcs_back #(
		.NUM_LEDS (NUM_LEDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (q_pop),
		.cfg        (cfg_q),
		.res        (res)
	);

endmodule

`default_nettype wire
